FILE: hw/rtl/byte_addressed_load_store_memory_unit_defines.svh
// assertion macros shared by the memory unit rtl
// no dependencies; included by the modules that carry assertions
`ifndef BYTE_ADDRESSED_LOAD_STORE_MEMORY_UNIT_DEFINES_SVH
`define BYTE_ADDRESSED_LOAD_STORE_MEMORY_UNIT_DEFINES_SVH

// clocked check, off while reset is asserted
`define BALSM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BALSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/balsm_pkg.sv
// shared types, constants and state codes of the byte-addressed memory unit
// no dependencies
package balsm_pkg;

	localparam int unsigned MEM_BYTES_DEF = 65536;
	localparam int unsigned CFG_W         = 13;
	localparam logic [CFG_W-1:0] RESET_BLOCKS = 13'd4096;
	localparam logic [7:0] RESET_FILL     = 8'ha5;
	localparam int unsigned NUM_BANKS     = 4;

	// access size codes
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;

	localparam logic MODE_WRITE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [1:0]  access_size;
		logic        sign_extend;
		logic [31:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        out_of_range;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} sts_t;

endpackage

FILE: hw/rtl/balsm_ram.sv
// generic single-port ram with registered read
// no dependencies
module balsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/balsm_ctrl.sv
// controller state machine: clearing pass, request issue, response strobe
// depends on balsm_pkg and the assertion macro header
`include "byte_addressed_load_store_memory_unit_defines.svh"

module balsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  balsm_pkg::sts_t   sts,
	output logic              busy,
	output logic              done,
	output balsm_pkg::cmd_t   cmd
);

	balsm_pkg::state_t state_q, state_d;
	logic              done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			balsm_pkg::ST_CLEAR: begin
				if (sts.clear_done) begin
					state_d = balsm_pkg::ST_IDLE;
				end
			end
			balsm_pkg::ST_IDLE: begin
				if (start) begin
					state_d = balsm_pkg::ST_RESP;
				end
			end
			balsm_pkg::ST_RESP: begin
				state_d = balsm_pkg::ST_IDLE;
			end
			default: begin
				state_d = balsm_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		cmd.clear  = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			balsm_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			balsm_pkg::ST_IDLE: begin
				busy      = 1'b0;
				cmd.issue = start;
			end
			balsm_pkg::ST_RESP: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= balsm_pkg::ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign done = done_q;

	`BALSM_ASSERT(a_done_in_idle, clk, arst_n, done |-> (state_q == balsm_pkg::ST_IDLE), "strobe outside idle")
	`BALSM_ASSERT(a_issue_to_resp, clk, arst_n, cmd.issue |=> (cmd.finish && !done), "issue not followed by response")
	`BALSM_ASSERT_ALWAYS(a_cmd_onehot, clk, $countones(cmd) <= 1, "conflicting datapath commands")

endmodule

FILE: hw/rtl/balsm_dp.sv
// datapath: size register, four byte banks, lane steering, range checks, result register
// depends on balsm_pkg, balsm_ram and the assertion macro header
`include "byte_addressed_load_store_memory_unit_defines.svh"

module balsm_dp #(
	parameter int unsigned MEM_BYTES = balsm_pkg::MEM_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  balsm_pkg::cmd_t             cmd,
	input  balsm_pkg::req_t             req,
	input  logic                        cfg_valid,
	input  logic [balsm_pkg::CFG_W-1:0] cfg_data,
	output balsm_pkg::sts_t             sts,
	output balsm_pkg::rsp_t             rsp
);

	localparam int unsigned NB         = balsm_pkg::NUM_BANKS;
	localparam int unsigned BANK_DEPTH = (MEM_BYTES + NB - 1) / NB;
	localparam int unsigned ROW_W      = $clog2(BANK_DEPTH);
	localparam logic [31:0] MEM_LIMIT  = 32'(MEM_BYTES);

	logic [balsm_pkg::CFG_W-1:0] size_q;
	logic [ROW_W-1:0]            clr_q;

	logic [31:0] lim;
	logic [31:0] blk_bytes;
	logic [31:0] addr_k [NB];
	logic [NB-1:0] used_k;
	logic [NB-1:0] ok_k;
	logic        bad;

	logic             ram_en;
	logic [NB-1:0]    ram_we;
	logic [ROW_W-1:0] ram_addr  [NB];
	logic [7:0]       ram_wdata [NB];
	logic [7:0]       ram_rdata [NB];

	// request held for the response cycle
	logic          mode_q;
	logic [1:0]    sz_q;
	logic          sx_q;
	logic [1:0]    off_q;
	logic [NB-1:0] rd_ok_q;
	logic          bad_q;

	logic [31:0]      value;
	balsm_pkg::rsp_t  rsp_q;

	// legal limit, saturated at the store size
	assign blk_bytes = {15'd0, size_q, 4'd0};
	assign lim       = (blk_bytes > MEM_LIMIT) ? MEM_LIMIT : blk_bytes;

	always_comb begin
		for (int k = 0; k < NB; k++) begin
			addr_k[k] = req.address + 32'(k);
			ok_k[k]   = addr_k[k] < lim;
		end
		used_k[0] = 1'b1;
		used_k[1] = req.access_size != balsm_pkg::SZ_BYTE;
		used_k[2] = req.access_size != balsm_pkg::SZ_BYTE && req.access_size != balsm_pkg::SZ_HALF;
		used_k[3] = used_k[2];
		bad       = |(used_k & ~ok_k);
	end

	// steer byte lanes onto banks; bank b holds byte k with (address + k) mod 4 == b
	always_comb begin
		logic [1:0] k_sel;
		ram_en = cmd.clear | cmd.issue;
		for (int b = 0; b < NB; b++) begin
			k_sel = 2'(b) - req.address[1:0];
			if (cmd.clear) begin
				ram_addr[b]  = clr_q;
				ram_we[b]    = 1'b1;
				ram_wdata[b] = balsm_pkg::RESET_FILL;
			end else begin
				ram_addr[b]  = addr_k[k_sel][ROW_W+1:2];
				ram_we[b]    = cmd.issue && (req.mode == balsm_pkg::MODE_WRITE)
					&& used_k[k_sel] && ok_k[k_sel];
				ram_wdata[b] = req.write_data[8*k_sel +: 8];
			end
		end
	end

	for (genvar b = 0; b < NB; b++) begin : g_bank
		balsm_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.en   (ram_en),
			.we   (ram_we[b]),
			.addr (ram_addr[b]),
			.wdata(ram_wdata[b]),
			.rdata(ram_rdata[b])
		);
	end

	assign sts.clear_done = clr_q == ROW_W'(BANK_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= balsm_pkg::RESET_BLOCKS;
			clr_q  <= '0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			mode_q  <= req.mode;
			sz_q    <= req.access_size;
			sx_q    <= req.sign_extend;
			off_q   <= req.address[1:0];
			rd_ok_q <= used_k & ok_k;
			bad_q   <= bad;
		end
	end

	// gather lanes back into byte order, then extend
	always_comb begin
		logic [31:0] raw;
		logic [1:0]  bank_sel;
		for (int k = 0; k < NB; k++) begin
			bank_sel       = off_q + 2'(k);
			raw[8*k +: 8]  = rd_ok_q[k] ? ram_rdata[bank_sel] : 8'd0;
		end
		if (mode_q == balsm_pkg::MODE_WRITE) begin
			value = '0;
		end else if (sx_q && sz_q == balsm_pkg::SZ_BYTE) begin
			value = {{24{raw[7]}}, raw[7:0]};
		end else if (sx_q && sz_q == balsm_pkg::SZ_HALF) begin
			value = {{16{raw[15]}}, raw[15:0]};
		end else begin
			value = raw;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.read_data    <= value;
			rsp_q.out_of_range <= bad_q;
		end
	end

	assign rsp = rsp_q;

	`BALSM_ASSERT(a_no_write_beyond, clk, arst_n, (|ram_we && !cmd.clear) |-> cmd.issue, "bank write without a request")
	`BALSM_ASSERT(a_clear_sweeps, clk, arst_n, (cmd.clear && !sts.clear_done) |=> (clr_q == $past(clr_q) + ROW_W'(1)), "clearing pass skipped a row")
	`BALSM_ASSERT(a_read_held, clk, arst_n, cmd.finish |-> !ram_en, "bank read data disturbed before capture")

endmodule

FILE: hw/rtl/byte_addressed_load_store_memory_unit.sv
// byte-addressed little-endian load/store memory; depends on balsm_pkg, balsm_ctrl, balsm_dp
// sequence: start taken in idle starts the registered bank read; the response state then
// loads the result register and done together, and busy stays high there, so a new request
// waits until the last is through; the receiver cannot stall, so nothing else limits it
// reset: busy stays high while the banks are filled with 0xa5
// one row a cycle; size_in_blocks resets to 4096 and config writes are taken at any time
module byte_addressed_load_store_memory_unit #(
	parameter int unsigned MEM_BYTES = balsm_pkg::MEM_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	// request channel: taken when start is high and busy is low
	input  logic                        start,
	output logic                        busy,
	input  balsm_pkg::req_t             req,

	// result: valid for exactly one cycle while done is high
	output logic                        done,
	output balsm_pkg::rsp_t             rsp,

	// size_in_blocks write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [balsm_pkg::CFG_W-1:0] cfg_data
);

	balsm_pkg::cmd_t cmd;
	balsm_pkg::sts_t sts;

	// the user must change the size register only between requests; the block does not enforce it and always accepts
	assign cfg_ready = 1'b1;

	// sequencing: clearing pass after reset, then idle / respond per request
	balsm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	// four byte banks with per-byte range check, lane steering and extension
	balsm_dp #(
		.MEM_BYTES(MEM_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_valid(cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule
